[sv/ordered_list_store_macros.svh]
`ifndef ORDERED_LIST_STORE_MACROS_SVH
`define ORDERED_LIST_STORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define OLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ols: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define OLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ols: next-cycle check failed");

`endif

[sv/ols_pkg.sv]
package ols_pkg;

    // Fixed payload widths of the two channels
    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int ENTRY_W = 32;

    // Request codes; code three changes nothing
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_DELETE     = 2'd2
    } t_mode;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_SH_PRIME,
        S_SHIFT,
        S_EMIT_START,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;
        logic apply;
        logic sh_prime;
        logic sh_step;
        logic emit_start;
        logic emit_step;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_shift;
        logic shift_last;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

[sv/ols_ifs.sv]
// Request channel: one transaction per list operation
interface ols_req_if import ols_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [MODE_W-1:0]  mode;
    logic signed [VALUE_W-1:0] value;
    logic        [POS_W-1:0]   position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

// Response channel: one transaction per listed entry
interface ols_rsp_if import ols_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ENTRY_W-1:0] entry_value;
    logic                      is_last;
    logic                      list_empty;
    logic                      insert_dropped;

    modport source (output valid, entry_value, is_last, list_empty, insert_dropped,
                    input ready);
    modport sink   (input valid, entry_value, is_last, list_empty, insert_dropped,
                    output ready);
endinterface

[sv/ols_ram.sv]
module ols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/ols_ctrl.sv]
module ols_ctrl import ols_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_status i_status,
    output logic    o_req_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = i_status.need_shift ? S_SH_PRIME : S_EMIT_START;
            end
            S_SH_PRIME: begin
                o_cmd.sh_prime = 1'b1;
                n_state        = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.sh_step = 1'b1;
                if (i_status.shift_last) begin
                    n_state = S_EMIT_START;
                end
            end
            S_EMIT_START: begin
                o_cmd.emit_start = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/ols_dp.sv]
module ols_dp import ols_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic        [MODE_W-1:0]  i_req_mode,
    input  logic signed [VALUE_W-1:0] i_req_value,
    input  logic        [POS_W-1:0]   i_req_position,
    input  logic                      i_rsp_ready,
    output logic                      o_rsp_valid,
    output logic signed [ENTRY_W-1:0] o_entry_value,
    output logic                      o_is_last,
    output logic                      o_list_empty,
    output logic                      o_insert_dropped
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int SUM_W = PTR_W + 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Circular slot arithmetic
    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] a);
        return (a == PTR_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] a);
        return (a == '0) ? PTR_W'(CAPACITY - 1) : a - 1'b1;
    endfunction

    // base + off where off < CAPACITY: one compare and subtract
    function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                  input logic [SUM_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Latched request
    logic        [MODE_W-1:0]  r_mode;
    logic signed [VALUE_W-1:0] r_value;
    logic        [POS_W-1:0]   r_pos;

    // List state and walk pointers
    logic [PTR_W-1:0] r_front;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [PTR_W-1:0] r_slot;
    logic [PTR_W-1:0] r_rslot;
    logic             r_dropped;

    // Output register
    logic                      r_out_valid;
    logic signed [ENTRY_W-1:0] r_out_value;
    logic                      r_out_last;
    logic                      r_out_empty;
    logic                      r_out_dropped;

    // RAM port signals
    logic                  ram_wr_en;
    logic [PTR_W-1:0]      ram_wr_addr;
    logic [VALUE_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [PTR_W-1:0]      ram_rd_addr;
    logic [VALUE_BITS-1:0] ram_rd_data;

    // Request decode
    logic             is_insert;
    logic             is_full;
    logic             is_empty;
    logic             pos_ok;
    logic             need_shift;
    logic             shift_last;
    logic             emit_last;
    logic             out_free;
    logic [PTR_W-1:0] pos_slot;

    assign is_insert  = (r_mode == MODE_PUSH_FRONT) || (r_mode == MODE_PUSH_BACK);
    assign is_full    = (r_count == CNT_W'(CAPACITY));
    assign is_empty   = (r_count == '0);
    assign pos_ok     = (r_mode == MODE_DELETE) && (CMP_W'(r_pos) < CMP_W'(r_count));
    assign need_shift = pos_ok && (r_pos != '0)
                        && ((CMP_W'(r_pos) + CMP_W'(1)) < CMP_W'(r_count));
    assign shift_last = (CMP_W'(r_idx) + CMP_W'(2)) >= CMP_W'(r_count);
    assign emit_last  = is_empty || ((CMP_W'(r_idx) + CMP_W'(1)) == CMP_W'(r_count));
    assign out_free   = !r_out_valid || i_rsp_ready;
    assign pos_slot   = slot_add(r_front, SUM_W'(r_pos));

    assign o_status.need_shift = need_shift;
    assign o_status.shift_last = shift_last;
    assign o_status.emit_last  = emit_last;
    assign o_status.out_free   = out_free;

    // RAM access: insert write, shift read/write pairs, emit reads
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_slot;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_slot;
        if (i_cmd.apply && is_insert && !is_full) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = VALUE_BITS'(r_value);
            ram_wr_addr = (r_mode == MODE_PUSH_FRONT) ? slot_dec(r_front)
                                                      : slot_add(r_front, SUM_W'(r_count));
        end
        if (i_cmd.sh_prime) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = r_rslot;
        end
        if (i_cmd.sh_step) begin
            ram_wr_en   = 1'b1;
            ram_rd_en   = !shift_last;
            ram_rd_addr = r_rslot;
        end
        if (i_cmd.emit_start) begin
            ram_rd_en   = !is_empty;
            ram_rd_addr = r_front;
        end
        if (i_cmd.emit_step) begin
            ram_rd_en   = !emit_last;
            ram_rd_addr = r_slot;
        end
    end

    ols_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_req_mode;
            r_value <= i_req_value;
            r_pos   <= i_req_position;
        end
    end

    // List state, walk pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_slot    <= '0;
            r_rslot   <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_dropped <= 1'b0;
            end
            if (i_cmd.apply) begin
                if (is_insert) begin
                    if (is_full) begin
                        r_dropped <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                        if (r_mode == MODE_PUSH_FRONT) begin
                            r_front <= slot_dec(r_front);
                        end
                    end
                end else if (pos_ok) begin
                    if (r_pos == '0) begin
                        // front removal just moves the front
                        r_front <= slot_inc(r_front);
                        r_count <= r_count - 1'b1;
                    end else if (need_shift) begin
                        r_idx   <= CNT_W'(r_pos);
                        r_slot  <= pos_slot;
                        r_rslot <= slot_inc(pos_slot);
                    end else begin
                        // back removal just shortens the list
                        r_count <= r_count - 1'b1;
                    end
                end
            end
            if (i_cmd.sh_prime) begin
                r_rslot <= slot_inc(r_rslot);
            end
            if (i_cmd.sh_step) begin
                r_idx  <= r_idx + 1'b1;
                r_slot <= slot_inc(r_slot);
                if (shift_last) begin
                    r_count <= r_count - 1'b1;
                end else begin
                    r_rslot <= slot_inc(r_rslot);
                end
            end
            if (i_cmd.emit_start) begin
                r_idx  <= '0;
                r_slot <= slot_inc(r_front);
            end
            if (i_cmd.emit_step && !emit_last) begin
                r_idx  <= r_idx + 1'b1;
                r_slot <= slot_inc(r_slot);
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_step) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_step) begin
            r_out_value   <= is_empty ? '0 : ENTRY_W'(ram_rd_data);
            r_out_last    <= emit_last;
            r_out_empty   <= is_empty;
            r_out_dropped <= r_dropped;
        end
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_entry_value    = r_out_value;
    assign o_is_last        = r_out_last;
    assign o_list_empty     = r_out_empty;
    assign o_insert_dropped = r_out_dropped;

endmodule

[sv/ordered_list_store.sv]
// Ordered list of up to CAPACITY values kept in a circular RAM.
// i_req (valid/ready): mode 0 inserts value at the front, 1 appends it at the
//   back, 2 removes the entry at position; out-of-range positions and code 3
//   leave the list as is. An insert into a full list is dropped and flagged.
// o_rsp (valid/ready): after every request the whole list front to back, one
//   transaction per entry, is_last on the final one; an empty list gives one
//   transaction with list_empty set and entry_value zero.
// Timing: one request at a time. A request is accepted only when the previous
//   listing has been fully loaded into the output register. After acceptance
//   the request passes APPLY, then EMIT_START, which starts the front read, and
//   EMIT, which loads the output register; a middle delete first goes through
//   SH_PRIME, one priming read, and SHIFT, one entry moved per cycle through
//   the single RAM port pair. Then one result per cycle while the receiver
//   takes them.
// Stall: a held o_rsp.ready freezes the output register and the list walk.
// Reset: the list is empty, front pointer zero; the RAM contents are not
//   cleared, since only written entries are ever read.
module ordered_list_store import ols_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ols_req_if.sink   i_req,
    ols_rsp_if.source o_rsp
);

    t_cmd    cmd;
    t_status status;
    logic    req_ready;

    ols_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (status),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    ols_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_req_mode       (i_req.mode),
        .i_req_value      (i_req.value),
        .i_req_position   (i_req.position),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_entry_value    (o_rsp.entry_value),
        .o_is_last        (o_rsp.is_last),
        .o_list_empty     (o_rsp.list_empty),
        .o_insert_dropped (o_rsp.insert_dropped)
    );

    assign i_req.ready = req_ready;

endmodule

[sv/ols_checker.sv]
`include "ordered_list_store_macros.svh"

module ols_checker import ols_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic signed [ENTRY_W-1:0] i_entry_value,
    input logic                      i_is_last,
    input logic                      i_list_empty,
    input logic                      i_insert_dropped
);

    // A stalled result holds
    `OLS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_entry_value) && $stable(i_is_last) && $stable(i_list_empty) && $stable(i_insert_dropped))

    // An empty listing is a single zero result; an empty list never follows a dropped insert
    `OLS_ASSERT_NOW(a_empty_form, i_clk, i_rst_n, i_rsp_valid && i_list_empty, i_is_last && (i_entry_value == '0) && !i_insert_dropped)

    // One request at a time: busy right after a request transaction
    `OLS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // No new request while a listing is still in progress
    `OLS_ASSERT_NOW(a_busy_in_listing, i_clk, i_rst_n, i_rsp_valid && !i_is_last, !i_req_ready)

endmodule

bind ordered_list_store ols_checker u_ols_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_entry_value    (o_rsp.entry_value),
    .i_is_last        (o_rsp.is_last),
    .i_list_empty     (o_rsp.list_empty),
    .i_insert_dropped (o_rsp.insert_dropped)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ols_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int CLK_HALF   = 6;
    localparam int LIMIT_NS   = 12_000_000;
    localparam int SETTLE_CYC = 16;
    localparam int MAX_PRINTS = 40;

    // Code three is not a member of t_mode; it leaves the list alone
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    typedef enum int {
        SEG_GROW,
        SEG_SHRINK,
        SEG_MIXED
    } t_seg_kind;

    // One listed entry as seen on the response channel
    typedef struct packed {
        logic signed [ENTRY_W-1:0] entry_value;
        logic                      is_last;
        logic                      list_empty;
        logic                      insert_dropped;
    } t_listing_entry;

    // Shadow copy of the list plus the listing entries still owed by the block
    class listing_scoreboard;
        logic signed [VALUE_W-1:0] shadow_list[$];
        t_listing_entry            pending_entries[$];
        int                        errors;
        int                        seen;

        function new();
            errors = 0;
            seen   = 0;
        endfunction

        function int pending();
            return pending_entries.size();
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTS)
                $display("tb: mismatch at listing entry %0d: %s", seen, msg);
            errors++;
        endtask

        // Apply one accepted request to the shadow list and queue its listing
        function void note_request(input logic [MODE_W-1:0]  mode,
                                   input logic signed [VALUE_W-1:0] value,
                                   input logic [POS_W-1:0]   position);
            logic           dropped;
            t_listing_entry ent;
            int             n;
            dropped = 1'b0;
            case (mode)
                MODE_PUSH_FRONT: begin
                    if (shadow_list.size() >= CAPACITY) dropped = 1'b1;
                    else shadow_list.push_front(value);
                end
                MODE_PUSH_BACK: begin
                    if (shadow_list.size() >= CAPACITY) dropped = 1'b1;
                    else shadow_list.push_back(value);
                end
                MODE_DELETE: begin
                    if (int'(position) < shadow_list.size()) shadow_list.delete(int'(position));
                end
                default: ;
            endcase

            n = shadow_list.size();
            if (n == 0) begin
                ent.entry_value    = '0;
                ent.is_last        = 1'b1;
                ent.list_empty     = 1'b1;
                ent.insert_dropped = dropped;
                pending_entries.push_back(ent);
            end else begin
                for (int k = 0; k < n; k++) begin
                    ent.entry_value    = shadow_list[k];
                    ent.is_last        = (k == n - 1);
                    ent.list_empty     = 1'b0;
                    ent.insert_dropped = dropped;
                    pending_entries.push_back(ent);
                end
            end
        endfunction

        // Compare one response transaction with the oldest owed entry
        task check_entry(input t_listing_entry got);
            t_listing_entry want;
            if (pending_entries.size() == 0) begin
                report($sformatf("unexpected transaction value %0d", got.entry_value));
            end else begin
                want = pending_entries.pop_front();
                if (got.entry_value !== want.entry_value)
                    report($sformatf("entry_value %0d, want %0d",
                                     got.entry_value, want.entry_value));
                if (got.is_last !== want.is_last)
                    report($sformatf("is_last %b, want %b", got.is_last, want.is_last));
                if (got.list_empty !== want.list_empty)
                    report($sformatf("list_empty %b, want %b",
                                     got.list_empty, want.list_empty));
                if (got.insert_dropped !== want.insert_dropped)
                    report($sformatf("insert_dropped %b, want %b",
                                     got.insert_dropped, want.insert_dropped));
            end
            seen++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;

    listing_scoreboard sb;

    ols_req_if req_if ();
    ols_rsp_if rsp_if ();

    ordered_list_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #LIMIT_NS;
        $display("tb: failure");
        $finish;
    end

    // Response side: check accepted transactions, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_entry('{rsp_if.entry_value, rsp_if.is_last,
                             rsp_if.list_empty, rsp_if.insert_dropped});
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // One request transaction, with a random idle gap in front
    task automatic send_request(input logic [MODE_W-1:0]         mode,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [POS_W-1:0]          position);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= mode;
        req_if.value    <= value;
        req_if.position <= position;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(mode, value, position);
    endtask

    // Hold off new requests until every owed listing entry has come back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Extremes and corner cases, starting from an empty list
    task automatic run_directed();
        send_request(MODE_DELETE,     32'sd0,          6'd0);   // delete on empty
        send_request(MODE_NOP,        32'sd0,          6'd0);   // unused code, empty
        send_request(MODE_PUSH_BACK,  32'sd5,          6'd0);
        send_request(MODE_DELETE,     32'sd0,          6'd0);   // remove only entry
        send_request(MODE_PUSH_BACK,  32'h7FFF_FFFF,   6'd0);   // tail after that
        send_request(MODE_PUSH_FRONT, 32'h8000_0000,   6'd0);
        send_request(MODE_PUSH_BACK,  32'sd0,          6'd0);
        send_request(MODE_PUSH_FRONT, -32'sd1,         6'd63);
        send_request(MODE_PUSH_BACK,  32'h5555_5555,   6'h2A);
        send_request(MODE_PUSH_FRONT, 32'hAAAA_AAAA,   6'h15);
        send_request(MODE_DELETE,     32'sd0,          6'd63);  // far out of range
        send_request(MODE_DELETE,     32'sd0,          6'd6);   // position == count
        send_request(MODE_DELETE,     32'h7FFF_FFFF,   6'd2);   // middle
        send_request(MODE_DELETE,     32'sd0,          6'd4);   // back
        send_request(MODE_DELETE,     32'sd0,          6'd0);   // front
        send_request(MODE_NOP,        32'h8000_0000,   6'd63);
        send_request(MODE_DELETE,     32'sd0,          6'd1);
        send_request(MODE_DELETE,     32'sd0,          6'd1);   // back of two
        send_request(MODE_DELETE,     -32'sd1,         6'd0);   // only entry again
        send_request(MODE_PUSH_FRONT, 32'sd1,          6'd63);
        send_request(MODE_PUSH_BACK,  32'h8000_0000,   6'd0);
        send_request(MODE_DELETE,     32'sd0,          6'd0);
    endtask

    // One random request shaped by the segment kind; flags whether it changes the list
    task automatic random_item(input t_seg_kind kind, output bit changes_list);
        int                  p;
        int                  n;
        int                  push_pct;
        int                  del_pct;
        logic [MODE_W-1:0]   m;
        logic [POS_W-1:0]    pos;
        n   = sb.shadow_list.size();
        p   = $urandom_range(99);
        pos = POS_W'($urandom_range(63));
        case (kind)
            SEG_GROW:   begin push_pct = 75; del_pct = 90; end
            SEG_SHRINK: begin push_pct = 20; del_pct = 90; end
            default:    begin push_pct = 45; del_pct = 88; end
        endcase

        if (p < push_pct || (p < del_pct && n == 0)) begin
            m = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            changes_list = (n < CAPACITY);
        end else if (p < del_pct) begin
            m = MODE_DELETE;
            case ($urandom_range(3))
                0:       pos = '0;
                1:       pos = POS_W'(n - 1);
                default: pos = POS_W'($urandom_range(n - 1));
            endcase
            changes_list = 1'b1;
        end else if (n < CAPACITY && $urandom_range(1)) begin
            // delete beyond the end: ignored
            m = MODE_DELETE;
            pos = POS_W'($urandom_range(63, n));
            changes_list = 1'b0;
        end else begin
            m = MODE_NOP;
            changes_list = 1'b0;
        end
        send_request(m, $urandom, pos);
    endtask

    // Random walk over the list size in short segments
    task automatic run_random(input int budget);
        int        done;
        int        seg_len;
        t_seg_kind kind;
        bit        changed;
        done = 0;
        while (done < budget) begin
            kind    = t_seg_kind'($urandom_range(2));
            seg_len = $urandom_range(24, 8);
            repeat (seg_len) begin
                random_item(kind, changed);
                if (changed) done++;
            end
        end
    endtask

    // Fill to capacity, overflow it, then trim both ends of the full list
    task automatic fill_list();
        while (sb.shadow_list.size() < CAPACITY)
            send_request($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                         $urandom, POS_W'($urandom_range(63)));
        send_request(MODE_PUSH_FRONT, $urandom, 6'd0);
        send_request(MODE_PUSH_BACK,  $urandom, 6'd63);
        send_request(MODE_NOP,        $urandom, 6'd63);
        send_request(MODE_PUSH_BACK,  $urandom, 6'd0);
        send_request(MODE_DELETE,     $urandom, 6'd63);
        send_request(MODE_DELETE,     $urandom, 6'd0);
    endtask

    // Main sequence
    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.mode     = '0;
        req_if.value    = '0;
        req_if.position = '0;
        rsp_if.ready    = 1'b0;
        sb              = new();
        tx_idle_pct     = 6;
        rx_idle_pct     = 72;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain();
        run_random(65);
        drain();

        tx_idle_pct = 72;
        rx_idle_pct = 6;
        run_random(65);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_list();
        run_random(40);
        drain();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d entries never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
